// ===== hdl/smkn_pkg.sv =====
package smkn_pkg;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 63;
    localparam int RANK_W   = 4;
    localparam int STATUS_W = 2;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [RANK_W-1:0]   t_rank;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_kind KIND_INSERT = 2'd0;
    localparam t_kind KIND_BELOW  = 2'd1;
    localparam t_kind KIND_ABOVE  = 2'd2;

    localparam t_status ST_FOUND     = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_INSERTED  = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    typedef struct packed {
        logic cmp_en;
        logic act_en;
        logic ins_en;
        logic below;
        logic above;
    } t_ctl;

endpackage

// ===== hdl/smkn_in_if.sv =====
interface smkn_in_if;
    logic               valid;
    logic               ready;
    smkn_pkg::t_kind    kind;
    smkn_pkg::t_key     key;
    smkn_pkg::t_rank    rank;

    modport source (output valid, output kind, output key, output rank, input ready);
    modport sink   (input valid, input kind, input key, input rank, output ready);
endinterface

// ===== hdl/smkn_out_if.sv =====
interface smkn_out_if;
    logic               valid;
    logic               ready;
    smkn_pkg::t_status  status;
    smkn_pkg::t_key     value;

    modport source (output valid, output status, output value, input ready);
    modport sink   (input valid, input status, input value, output ready);
endinterface

// ===== hdl/sorted_multiset_kth_neighbor_core.sv =====
// Sorted multiset of 63-bit keys with k-th neighbour queries.
// Input channel i_in (valid/ready) carries kind, key and rank; a transfer
// happens when valid and ready are both high. Kind insert adds the key in
// ascending order, kind below returns the rank-th largest key at or below
// the key, kind above the rank-th smallest key at or above it.
// Output channel o_out carries one status/value result per input transfer.
// Keys live in a row of CAPACITY cells; insert shifts the larger keys one
// cell up together, queries compare in every cell at once, pick the
// boundary cell from a window of MAX_RANK (at most 15) neighbour flags,
// then gather the hit through a registered radix-4 OR tree.
// One item is in flight at a time: i_in.ready is high only in the idle
// state, and an item passes through the compare, act and tree states
// before its result goes to the output register.
// The output register decouples the sides: a new item is taken while a
// result still waits; if the receiver stalls, the next result holds in the
// block and i_in.ready stays low until the output register frees. Reset
// empties the store at once; key storage is not cleared.
module sorted_multiset_kth_neighbor_core #(
    parameter int CAPACITY = 256,
    parameter int MAX_RANK = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    smkn_in_if.sink           i_in,
    smkn_out_if.source        o_out
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WIN    = (MAX_RANK < 15) ? MAX_RANK : 15;
    localparam int LEVELS = ($clog2(CAPACITY) + 1) / 2;
    localparam int LVL_W  = $clog2(LEVELS + 1);
    localparam int LEAF_W = smkn_pkg::KEY_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_ACT,
        S_TREE,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [LVL_W-1:0]   r_lvl;
    smkn_pkg::t_kind    r_kind;
    smkn_pkg::t_key     r_query;
    logic [WIN-1:0]     r_rank_oh;
    logic               r_drop;
    logic               r_out_valid;
    smkn_pkg::t_status  r_out_status;
    smkn_pkg::t_key     r_out_value;

    smkn_pkg::t_ctl     w_ctl;
    logic               w_full;
    logic [WIN-1:0]     w_rank_oh;
    smkn_pkg::t_key     w_key  [CAPACITY];
    logic [CAPACITY-1:0] w_le;
    logic [CAPACITY-1:0] w_lt;
    logic [LEAF_W-1:0]  w_leaf [CAPACITY];
    logic [LEAF_W-1:0]  w_root;

    assign w_full = r_count == CNT_W'(CAPACITY);

    always_comb begin
        for (int k = 0; k < WIN; k++) begin
            w_rank_oh[k] = i_in.rank == smkn_pkg::RANK_W'(k + 1);
        end
    end

    always_comb begin
        w_ctl.cmp_en = r_state == S_CMP;
        w_ctl.act_en = r_state == S_ACT;
        w_ctl.ins_en = (r_state == S_ACT) && (r_kind == smkn_pkg::KIND_INSERT) && !w_full;
        w_ctl.below  = r_kind == smkn_pkg::KIND_BELOW;
        w_ctl.above  = r_kind == smkn_pkg::KIND_ABOVE;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : gen_cell
        smkn_pkg::t_key w_prev_key;
        logic           w_prev_le;
        logic [WIN-1:0] w_ahead;
        logic [WIN-1:0] w_behind;

        if (i > 0) begin : gen_prev
            assign w_prev_key = w_key[i-1];
            assign w_prev_le  = w_le[i-1];
        end else begin : gen_first
            assign w_prev_key = '0;
            assign w_prev_le  = 1'b1;
        end

        for (genvar k = 0; k < WIN; k++) begin : gen_win
            if (i + k + 1 < CAPACITY) begin : gen_ahead_in
                assign w_ahead[k] = w_le[i+k+1];
            end else begin : gen_ahead_out
                assign w_ahead[k] = 1'b0;
            end
            if (i - k - 1 >= 0) begin : gen_behind_in
                assign w_behind[k] = w_lt[i-k-1];
            end else if (i - k - 1 == -1) begin : gen_behind_edge
                assign w_behind[k] = 1'b1;
            end else begin : gen_behind_out
                assign w_behind[k] = 1'b0;
            end
        end

        smkn_cell #(
            .INDEX (i),
            .CNT_W (CNT_W),
            .WIN   (WIN)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_query     (r_query),
            .i_rank_oh   (r_rank_oh),
            .i_count     (r_count),
            .i_prev_key  (w_prev_key),
            .i_prev_le   (w_prev_le),
            .i_le_ahead  (w_ahead),
            .i_lt_behind (w_behind),
            .o_key       (w_key[i]),
            .o_le        (w_le[i]),
            .o_lt        (w_lt[i]),
            .o_leaf      (w_leaf[i])
        );
    end

    smkn_or_tree #(
        .N (CAPACITY),
        .W (LEAF_W)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_root (w_root)
    );

    assign i_in.ready   = r_state == S_IDLE;
    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out_status;
    assign o_out.value  = r_out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_kind    <= i_in.kind;
                        r_query   <= i_in.key;
                        r_rank_oh <= w_rank_oh;
                        r_state   <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_ACT;
                end
                S_ACT: begin
                    if (w_ctl.ins_en) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_drop  <= w_full;
                    r_lvl   <= LVL_W'(LEVELS - 1);
                    r_state <= S_TREE;
                end
                S_TREE: begin
                    r_lvl <= r_lvl - LVL_W'(1);
                    if (r_lvl == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= w_root[smkn_pkg::KEY_W-1:0];
                        if (r_kind == smkn_pkg::KIND_INSERT) begin
                            r_out_status <= r_drop ? smkn_pkg::ST_FULL : smkn_pkg::ST_INSERTED;
                        end else begin
                            r_out_status <= w_root[smkn_pkg::KEY_W] ? smkn_pkg::ST_FOUND
                                                                    : smkn_pkg::ST_NOT_FOUND;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/smkn_cell.sv =====
module smkn_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 9,
    parameter int WIN   = 8
) (
    input  logic                  i_clk,
    input  smkn_pkg::t_ctl        i_ctl,
    input  smkn_pkg::t_key        i_query,
    input  logic [WIN-1:0]        i_rank_oh,
    input  logic [CNT_W-1:0]      i_count,
    input  smkn_pkg::t_key        i_prev_key,
    input  logic                  i_prev_le,
    input  logic [WIN-1:0]        i_le_ahead,
    input  logic [WIN-1:0]        i_lt_behind,
    output smkn_pkg::t_key        o_key,
    output logic                  o_le,
    output logic                  o_lt,
    output logic [smkn_pkg::KEY_W:0] o_leaf
);

    smkn_pkg::t_key r_key;
    logic           r_le;
    logic           r_lt;
    logic           r_hit;
    logic           w_valid;
    logic           w_hit_below;
    logic           w_hit_above;
    logic [WIN:0]   w_lt_ext;
    logic [WIN-1:0] w_edge;
    logic [WIN:0]   w_le_ext;
    logic [WIN-1:0] w_le_edge;

    assign w_valid  = CNT_W'(INDEX) < i_count;
    assign w_lt_ext = {i_lt_behind, r_lt};
    assign w_le_ext = {i_le_ahead, r_le};

    always_comb begin
        for (int k = 0; k < WIN; k++) begin
            w_edge[k]    = w_lt_ext[k+1] & ~w_lt_ext[k];
            w_le_edge[k] = w_le_ext[k] & ~w_le_ext[k+1];
        end
    end

    assign w_hit_below = |(i_rank_oh & w_le_edge);
    assign w_hit_above = w_valid && |(i_rank_oh & w_edge);

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_le <= w_valid && (r_key <= i_query);
            r_lt <= w_valid && (r_key < i_query);
        end
        if (i_ctl.act_en) begin
            r_hit <= (i_ctl.below && w_hit_below) || (i_ctl.above && w_hit_above);
        end
        if (i_ctl.ins_en && !r_le) begin
            r_key <= i_prev_le ? i_query : i_prev_key;
        end
    end

    assign o_key  = r_key;
    assign o_le   = r_le;
    assign o_lt   = r_lt;
    assign o_leaf = r_hit ? {1'b1, r_key} : '0;

endmodule

// ===== hdl/smkn_or_tree.sv =====
module smkn_or_tree #(
    parameter int N = 256,
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_leaf [N],
    output logic [W-1:0] o_root
);

    localparam int LEVELS = ($clog2(N) + 1) / 2;
    localparam int LEAVES = 4 ** LEVELS;
    localparam int INNER  = (LEAVES - 1) / 3;

    logic [W-1:0] w_leaf [LEAVES];
    logic [W-1:0] w_kid  [INNER][4];
    logic [W-1:0] r_node [INNER];

    for (genvar g = 0; g < LEAVES; g++) begin : gen_leaf
        if (g < N) begin : gen_used
            assign w_leaf[g] = i_leaf[g];
        end else begin : gen_pad
            assign w_leaf[g] = '0;
        end
    end

    for (genvar j = 0; j < INNER; j++) begin : gen_node
        for (genvar k = 0; k < 4; k++) begin : gen_kid
            if (4 * j + k + 1 >= INNER) begin : gen_from_leaf
                assign w_kid[j][k] = w_leaf[4 * j + k + 1 - INNER];
            end else begin : gen_from_node
                assign w_kid[j][k] = r_node[4 * j + k + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < INNER; j++) begin
            r_node[j] <= w_kid[j][0] | w_kid[j][1] | w_kid[j][2] | w_kid[j][3];
        end
    end

    assign o_root = r_node[0];

endmodule
